>>> rtl/sawrs_pkg.sv
// Shared types and constants for the stop-and-wait retransmit sender.
`default_nettype none
package sawrs_pkg;

  localparam int SEQ_W    = 32;
  localparam int LEN_W    = 11;
  localparam int FLEN_W   = 16;
  localparam int TICK_W   = 16;
  localparam int TRY_W    = 8;
  localparam int CFG_W    = 16;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  localparam logic [1:0] EV_SEND   = 2'd0;
  localparam logic [1:0] EV_ACKED  = 2'd1;
  localparam logic [1:0] EV_FAILED = 2'd2;

  localparam logic       CFG_TIMEOUT = 1'b0;
  localparam logic       CFG_TRIES   = 1'b1;

  localparam logic [7:0]        TYPE_ACK       = 8'd6;
  localparam logic [LEN_W-1:0]  HDR_BYTES      = 11'd13;
  localparam logic [FLEN_W-1:0] MAX_PAYLOAD    = 16'd1200;
  localparam logic [FLEN_W-1:0] TOPIC_CAPACITY = 16'd128;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [TRY_W-1:0]  TRIES_RESET   = 8'd10;

  typedef struct packed {
    logic [1:0]        action;
    logic [SEQ_W-1:0]  send_seq;
    logic [7:0]        rx_type;
    logic [SEQ_W-1:0]  rx_ack;
    logic [LEN_W-1:0]  rx_length;
    logic [FLEN_W-1:0] rx_topic_length;
    logic [FLEN_W-1:0] rx_data_length;
  } item_t;

  typedef struct packed {
    logic             vld;
    logic [1:0]       evt;
    logic [SEQ_W-1:0] seq;
  } result_t;

  typedef struct packed {
    logic pend;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/sawrs_hdr_chk.sv
// Length and field checks on a received packet header.
`default_nettype none
module sawrs_hdr_chk (
  input  wire logic [sawrs_pkg::LEN_W-1:0]  len,
  input  wire logic [sawrs_pkg::FLEN_W-1:0] tlen,
  input  wire logic [sawrs_pkg::FLEN_W-1:0] dlen,
  output logic                               ok
);

  logic [17:0] len_x;
  logic [17:0] topic_end;
  logic [17:0] data_end;
  logic [17:0] data_off;
  logic        len_ok;
  logic        topic_ok;
  logic        data_ok;

  always_comb begin
    len_x     = {7'd0, len};
    topic_end = 18'({7'd0, sawrs_pkg::HDR_BYTES}) + {2'd0, tlen};
    data_off  = (tlen != '0) ? topic_end : 18'({7'd0, sawrs_pkg::HDR_BYTES});
    data_end  = data_off + {2'd0, dlen};
    len_ok    = len >= sawrs_pkg::HDR_BYTES;
    topic_ok  = (tlen == '0) ||
                ((topic_end <= len_x) && (tlen < sawrs_pkg::TOPIC_CAPACITY));
    data_ok   = (dlen == '0) ||
                ((data_end <= len_x) && (dlen <= sawrs_pkg::MAX_PAYLOAD));
    ok        = len_ok && topic_ok && data_ok;
  end

endmodule
`default_nettype wire

>>> rtl/sawrs_ctrl.sv
// Sender state and the per-item decision: send, timer, retry count and ack match.
`default_nettype none
module sawrs_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire sawrs_pkg::item_t              item,
  input  wire logic [sawrs_pkg::TICK_W-1:0]  timeout_ticks,
  input  wire logic [sawrs_pkg::TRY_W-1:0]   max_tries,
  output sawrs_pkg::result_t                 res,
  output sawrs_pkg::status_t                 status
);

  logic                          pend_r, pend_nxt;
  logic [sawrs_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic [sawrs_pkg::TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic [sawrs_pkg::TRY_W-1:0]   tries_r, tries_nxt;

  logic [sawrs_pkg::TICK_W-1:0]  limit;
  logic [sawrs_pkg::TRY_W-1:0]   tmax;
  logic [sawrs_pkg::TICK_W-1:0]  elapsed_inc;
  logic [sawrs_pkg::TRY_W-1:0]   tries_inc;
  logic                          hdr_ok;

  sawrs_hdr_chk u_hdr_chk (
    .len  (item.rx_length),
    .tlen (item.rx_topic_length),
    .dlen (item.rx_data_length),
    .ok   (hdr_ok)
  );

  always_comb begin
    // A zero register value acts as one.
    limit       = (timeout_ticks == '0) ? sawrs_pkg::TICK_W'(1) : timeout_ticks;
    tmax        = (max_tries == '0) ? sawrs_pkg::TRY_W'(1) : max_tries;
    elapsed_inc = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
    tries_inc   = (tries_r != '1) ? tries_r + 1'b1 : tries_r;

    pend_nxt    = pend_r;
    seq_nxt     = seq_r;
    elapsed_nxt = elapsed_r;
    tries_nxt   = tries_r;
    res.vld     = 1'b0;
    res.evt     = sawrs_pkg::EV_SEND;
    res.seq     = seq_r;

    if (go) begin
      case (item.action)
        sawrs_pkg::ACT_START: begin
          if (!pend_r) begin
            pend_nxt    = 1'b1;
            seq_nxt     = item.send_seq;
            elapsed_nxt = '0;
            tries_nxt   = '0;
            res.vld     = 1'b1;
            res.seq     = item.send_seq;
          end
        end
        sawrs_pkg::ACT_TICK: begin
          if (pend_r) begin
            if (elapsed_inc < limit) begin
              elapsed_nxt = elapsed_inc;
            end else begin
              elapsed_nxt = '0;
              tries_nxt   = tries_inc;
              res.vld     = 1'b1;
              if (tries_inc >= tmax) begin
                pend_nxt = 1'b0;
                res.evt  = sawrs_pkg::EV_FAILED;
              end
            end
          end
        end
        sawrs_pkg::ACT_RX: begin
          if (pend_r && hdr_ok && (item.rx_type == sawrs_pkg::TYPE_ACK) &&
              (item.rx_ack == seq_r)) begin
            pend_nxt    = 1'b0;
            elapsed_nxt = '0;
            res.vld     = 1'b1;
            res.evt     = sawrs_pkg::EV_ACKED;
          end
        end
        default: begin
        end
      endcase
    end
    status.pend = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      seq_r     <= '0;
      elapsed_r <= '0;
      tries_r   <= '0;
    end else begin
      pend_r    <= pend_nxt;
      seq_r     <= seq_nxt;
      elapsed_r <= elapsed_nxt;
      tries_r   <= tries_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/stop_and_wait_retransmit_sender.sv
// Top level of the stop-and-wait retransmit sender: input register, output register, config.
`default_nettype none
// The sender takes one item per cycle unless the input stalls: a start loads a sequence
// number and emits a transmit event, ticks run the retransmit timer, and a received header
// that passes the length checks and acknowledges the pending number ends the send. An item
// is held in the input register and its result, if any, is registered in the output
// register; the sustained rate is set by the state update in the controller. The input
// stalls only when the output register holds a result that the downstream side stalls.
// Configuration writes are always ready; index 0 is the timeout in ticks, index 1 the
// maximum number of tries.
module stop_and_wait_retransmit_sender (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_action,
  input  wire logic [sawrs_pkg::SEQ_W-1:0]    in_send_seq,
  input  wire logic [7:0]                     in_rx_type,
  input  wire logic [sawrs_pkg::SEQ_W-1:0]    in_rx_ack,
  input  wire logic [sawrs_pkg::LEN_W-1:0]    in_rx_length,
  input  wire logic [sawrs_pkg::FLEN_W-1:0]   in_rx_topic_length,
  input  wire logic [sawrs_pkg::FLEN_W-1:0]   in_rx_data_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_event_res,
  output logic [sawrs_pkg::SEQ_W-1:0]         out_event_seq,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [sawrs_pkg::CFG_W-1:0]    cfg_data
);

  logic                          in_valid_r;
  sawrs_pkg::item_t              item_r;
  logic                          out_valid_r;
  logic [1:0]                    out_res_r;
  logic [sawrs_pkg::SEQ_W-1:0]   out_seq_r;
  logic [sawrs_pkg::TICK_W-1:0]  timeout_r;
  logic [sawrs_pkg::TRY_W-1:0]   tries_max_r;
  logic                          adv;
  logic                          go;
  sawrs_pkg::result_t            res;
  sawrs_pkg::status_t            status;

  // The staged item moves on whenever the output register is free or being emptied.
  assign adv       = !out_valid_r || !out_stall;
  assign go        = in_valid_r && adv;
  assign in_stall  = in_valid_r && !adv;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_event_res = out_res_r;
  assign out_event_seq = out_seq_r;

  sawrs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .item          (item_r),
    .timeout_ticks (timeout_r),
    .max_tries     (tries_max_r),
    .res           (res),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.action          <= in_action;
      item_r.send_seq        <= in_send_seq;
      item_r.rx_type         <= in_rx_type;
      item_r.rx_ack          <= in_rx_ack;
      item_r.rx_length       <= in_rx_length;
      item_r.rx_topic_length <= in_rx_topic_length;
      item_r.rx_data_length  <= in_rx_data_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_res_r <= res.evt;
      out_seq_r <= res.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= sawrs_pkg::TIMEOUT_RESET;
      tries_max_r <= sawrs_pkg::TRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sawrs_pkg::CFG_TIMEOUT: timeout_r   <= cfg_data;
        sawrs_pkg::CFG_TRIES:   tries_max_r <= cfg_data[sawrs_pkg::TRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // An acknowledgement or failure ends the pending send.
  a_end_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.vld && (res.evt == sawrs_pkg::EV_ACKED || res.evt == sawrs_pkg::EV_FAILED))
    |=> !status.pend)
    else $error("pending send survived an ack or failure event");

  // A start taken while idle shows a transmit event on the next cycle.
  a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item_r.action == sawrs_pkg::ACT_START && !status.pend)
    |=> (out_valid_r && out_res_r == sawrs_pkg::EV_SEND))
    else $error("start from idle did not emit a transmit event");

  // The sender only becomes busy together with a transmit event.
  a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.pend) |-> (out_valid_r && out_res_r == sawrs_pkg::EV_SEND))
    else $error("send became pending without a transmit event");
`endif

endmodule
`default_nettype wire
